// ----- src/pfb_pkg.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer fill package
// Shared types, constants and helpers for the packed-pixel frame store.
// ---------------------------------------------------------------------------
package pfb_pkg;

  localparam int unsigned STORE_BYTES_DEF   = 131072;
  localparam int unsigned MAX_DIMENSION_DEF = 1024;

  // Width of the full frame address arithmetic: row * pitch + byte offset
  // never reaches 2**22 for 11-bit dimensions.
  localparam int unsigned FA_W = 22;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [1:0] FMT_1BPP = 2'd0;
  localparam logic [1:0] FMT_2BPP = 2'd1;
  localparam logic [1:0] FMT_4BPP = 2'd2;

  localparam logic [7:0] MASK_1BPP = 8'h80;
  localparam logic [7:0] MASK_2BPP = 8'hC0;
  localparam logic [7:0] MASK_4BPP = 8'hF0;

  typedef struct packed {
    logic        mode;
    logic [9:0]  x_start;
    logic [9:0]  y_start;
    logic [10:0] x_end;
    logic [10:0] y_end;
    logic [3:0]  color;
    logic        abort_on_clip;
    logic [16:0] read_address;
  } pfb_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [20:0] pixels_written;
    logic        clipped;
  } pfb_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_DONE,
    ST_SETUP,
    ST_ROW,
    ST_PIX,
    ST_MODIFY
  } pfb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read_issue;
    logic setup;
    logic row_start;
    logic next_row;
    logic skip_pix;
    logic set_clip;
    logic pix_read;
    logic pix_write;
    logic finish;
  } pfb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic y_in;
    logic y_oob;
    logic x_in;
    logic x_oob;
    logic addr_oob;
    logic abort;
  } pfb_status_t;

  // Left-aligned pixel mask for a format given as log2 of bits per pixel.
  function automatic logic [7:0] pix_base_mask(input logic [1:0] lg);
    logic [7:0] m;
    unique case (lg)
      FMT_1BPP: m = MASK_1BPP;
      FMT_2BPP: m = MASK_2BPP;
      default:  m = MASK_4BPP;
    endcase
    return m;
  endfunction

endpackage

// ----- src/packed_framebuffer_fill.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer fill
// Frame store of packed 1, 2 or 4 bit pixels with rectangle fill and byte read.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be held off, so the
// receiver must take it then. A read request passes through the read-issue
// and read-done states before its result is registered and strobed. A fill
// takes a setup step, a row check for each row (including the check that
// ends the walk), a read then a write of the one frame store port pair for
// each painted pixel, a single step for each skipped pixel, a step to leave
// each row that is entered, and a final step for the result.
// Configuration writes are always accepted and must only be made while the
// block is idle.
module packed_framebuffer_fill import pfb_pkg::*; #(
  parameter int unsigned STORE_BYTES   = STORE_BYTES_DEF,
  parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  pfb_in_t               request,
  output logic                  done,
  output pfb_out_t              result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pfb_cmd_t    cmd;
  pfb_status_t status;

  assign cfg_ready = 1'b1;

  pfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .read_req (request.mode),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  pfb_dp #(
    .STORE_BYTES   (STORE_BYTES),
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .done      (done)
  );

endmodule

// ----- src/pfb_store.sv -----
// ---------------------------------------------------------------------------
// Frame store RAM
// Byte-wide simple dual-port memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module pfb_store #(
  parameter int unsigned DEPTH  = 131072,
  parameter int unsigned ADDR_W = 17
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/pfb_ctrl.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer controller
// Sequences reads and the raster walk of a rectangle fill.
// ---------------------------------------------------------------------------
module pfb_ctrl import pfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        read_req,
  input  pfb_status_t status,
  output logic        busy,
  output pfb_cmd_t    cmd
);

  pfb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = read_req ? ST_RD_ADDR : ST_SETUP;
        end
      end
      ST_RD_ADDR: begin
        cmd.read_issue = 1'b1;
        state_next     = ST_RD_DONE;
      end
      ST_RD_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_ROW;
      end
      ST_ROW: begin
        priority if (!status.y_in) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (status.y_oob) begin
          // Every remaining row lies below the image.
          cmd.set_clip = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.row_start = 1'b1;
          state_next    = ST_PIX;
        end
      end
      ST_PIX: begin
        priority if (!status.x_in) begin
          cmd.next_row = 1'b1;
          state_next   = ST_ROW;
        end else if (status.x_oob) begin
          // The rest of the row lies right of the image.
          cmd.set_clip = 1'b1;
          if (status.abort) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.next_row = 1'b1;
            state_next   = ST_ROW;
          end
        end else if (status.addr_oob) begin
          cmd.set_clip = 1'b1;
          if (status.abort) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.skip_pix = 1'b1;
          end
        end else begin
          cmd.pix_read = 1'b1;
          state_next   = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        cmd.pix_write = 1'b1;
        state_next    = ST_PIX;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  a_read_then_write: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_read |=> cmd.pix_write)
    else $error("pixel read not followed by its write");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && read_req) |=> ##1 cmd.finish)
    else $error("read request did not finish in two cycles");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !busy)
    else $error("controller still busy after finishing a request");

endmodule

// ----- src/pfb_dp.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer datapath
// Configuration registers, request latch, raster counters, address and
// pixel merge logic, and the frame store.
// ---------------------------------------------------------------------------
module pfb_dp import pfb_pkg::*; #(
  parameter int unsigned STORE_BYTES   = STORE_BYTES_DEF,
  parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  pfb_in_t               request,
  input  pfb_cmd_t              cmd,
  output pfb_status_t           status,
  output pfb_out_t              result,
  output logic                  done
);

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned MAX_DIM_CLIP = (MAX_DIMENSION > 2047) ? 2047 : MAX_DIMENSION;
  localparam logic [10:0] MAX_DIM_L = 11'(MAX_DIM_CLIP);
  localparam logic [FA_W-1:0] STORE_LIMIT = FA_W'(STORE_BYTES);

  logic [1:0]  pixel_format;
  logic [10:0] image_width;
  logic [10:0] image_height;

  pfb_in_t           req;
  logic [10:0]       x;
  logic [10:0]       y;
  logic [FA_W-1:0]   row_base;
  logic [20:0]       count;
  logic              clipped;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_mask;
  logic [7:0]        wr_bits;

  logic [1:0]        lg;
  logic [10:0]       w;
  logic [10:0]       h;
  logic [13:0]       pitch_bits;
  logic [10:0]       pitch;
  logic [12:0]       x_bits;
  logic [FA_W-1:0]   addr;
  logic [2:0]        pos;
  logic [7:0]        val_top;
  logic [FA_W-1:0]   rd_full;
  logic              rd_ok;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_1BPP;
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Format code 3 behaves as four bits per pixel.
  assign lg = (pixel_format >= FMT_4BPP) ? FMT_4BPP : pixel_format;
  assign w  = (image_width  > MAX_DIM_L) ? MAX_DIM_L : image_width;
  assign h  = (image_height > MAX_DIM_L) ? MAX_DIM_L : image_height;

  assign pitch_bits = (14'(w) << lg) + 14'd7;
  assign pitch      = pitch_bits[13:3];

  assign x_bits = 13'(x) << lg;
  assign pos    = x_bits[2:0];
  assign addr   = row_base + FA_W'(x_bits[12:3]);

  always_comb begin
    unique case (lg)
      FMT_1BPP: val_top = {(req.color != 4'd0), 7'd0};
      FMT_2BPP: val_top = {req.color[1:0], 6'd0};
      default:  val_top = {req.color, 4'd0};
    endcase
  end

  assign status.y_in     = (y < req.y_end);
  assign status.y_oob    = (y >= h);
  assign status.x_in     = (x < req.x_end);
  assign status.x_oob    = (x >= w);
  assign status.addr_oob = (addr >= STORE_LIMIT);
  assign status.abort    = req.abort_on_clip;

  assign rd_full = FA_W'(req.read_address);
  assign rd_ok   = (rd_full < STORE_LIMIT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y       <= {1'b0, request.y_start};
      count   <= '0;
      clipped <= 1'b0;
    end else begin
      if (cmd.next_row) begin
        y <= y + 11'd1;
      end
      if (cmd.pix_write) begin
        count <= count + 21'd1;
      end
      if (cmd.set_clip) begin
        clipped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      row_base <= FA_W'(y) * FA_W'(pitch);
    end else if (cmd.next_row) begin
      row_base <= row_base + FA_W'(pitch);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_start) begin
      x <= {1'b0, req.x_start};
    end else if (cmd.skip_pix || cmd.pix_write) begin
      x <= x + 11'd1;
    end
  end

  // Hold the target of the read-modify-write until the byte comes back.
  always_ff @(posedge clk) begin
    if (cmd.pix_read) begin
      wr_addr <= addr[ADDR_W-1:0];
      wr_mask <= pix_base_mask(lg) >> pos;
      wr_bits <= val_top >> pos;
    end
  end

  assign mem_re    = cmd.read_issue | cmd.pix_read;
  assign mem_raddr = cmd.read_issue ? rd_full[ADDR_W-1:0] : addr[ADDR_W-1:0];

  pfb_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (cmd.pix_write),
    .waddr (wr_addr),
    .wdata ((mem_rdata & ~wr_mask) | wr_bits),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (req.mode) begin
        result.read_data      <= rd_ok ? mem_rdata : 8'd0;
        result.pixels_written <= '0;
        result.clipped        <= 1'b0;
      end else begin
        result.read_data      <= 8'd0;
        result.pixels_written <= count;
        result.clipped        <= clipped | cmd.set_clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_write_only_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_write |-> !req.mode)
    else $error("frame store written during a read request");

endmodule
